/* hw/rtl/lifo_arena_allocator_top_defines.svh */
// Assertion macros for the LIFO arena allocator.
// Included by the top level; no other dependencies.
`ifndef LIFO_ARENA_ALLOCATOR_TOP_DEFINES_SVH
`define LIFO_ARENA_ALLOCATOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define LAA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("laa assertion failed");
`define LAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("laa assertion failed");
`else
`define LAA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/laa_pkg.sv */
// Shared types and codes for the LIFO arena allocator.
// No dependencies; used by laa_step and the top level.
`timescale 1ns / 1ps
package laa_pkg;

	localparam int ARENA_MAX    = 65536;
	localparam int RECORD_DEPTH = 32;

	localparam int TOP_W  = 17;
	localparam int CNT_W  = 6;
	localparam int SIZE_W = 24;
	localparam int TOT_W  = 32;
	localparam int OFS_W  = 16;
	localparam int CFG_W  = 17;
	localparam int IDX_W  = 1;

	localparam logic [2:0] ST_ARENA   = 3'd0;
	localparam logic [2:0] ST_SPILLED = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_NULLBLK = 3'd3;
	localparam logic [2:0] ST_FREED   = 3'd4;
	localparam logic [2:0] ST_IGNORED = 3'd5;
	localparam logic [2:0] ST_UNDER   = 3'd6;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [IDX_W-1:0] REG_ARENA_BYTES  = 1'd0;
	localparam logic [IDX_W-1:0] REG_RECORD_LIMIT = 1'd1;

	typedef struct packed {
		logic              kind;
		logic [SIZE_W-1:0] request_size;
		logic              release_nonnull;
	} laa_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [OFS_W-1:0]  block_offset;
		logic [SIZE_W-1:0] recorded_size;
		logic [TOT_W-1:0]  bytes_in_use;
		logic [TOT_W-1:0]  peak_bytes;
		logic [CNT_W-1:0]  records_held;
	} laa_result_t;

	typedef struct packed {
		logic [TOP_W-1:0] top;
		logic [CNT_W-1:0] count;
		logic [TOT_W-1:0] total;
		logic [TOT_W-1:0] peak;
	} laa_state_t;

	typedef struct packed {
		logic              spilled;
		logic [SIZE_W-1:0] size;
	} laa_rec_t;

endpackage

/* hw/rtl/laa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module laa_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/laa_step.sv */
// Single-pass allocate/free logic: next state, result and record write.
// Depends on laa_pkg.
`timescale 1ns / 1ps
module laa_step #(
	parameter int MAX_ALIGN    = 16
) (
	input  laa_pkg::laa_state_t            state,
	input  laa_pkg::laa_item_t             item,
	input  logic [laa_pkg::CFG_W-1:0]      arena_cfg,
	input  logic [laa_pkg::CNT_W-1:0]      limit_cfg,
	input  laa_pkg::laa_rec_t              rec_top,
	output laa_pkg::laa_state_t            state_next,
	output laa_pkg::laa_result_t           result,
	output logic                           rec_we,
	output laa_pkg::laa_rec_t              rec_wdata
);
	import laa_pkg::*;

	localparam int AL_W = $clog2(MAX_ALIGN) + 1;

	logic [TOP_W-1:0]  arena;
	logic [CNT_W-1:0]  limit;
	logic              full;
	logic [TOP_W-1:0]  avail;
	logic [TOP_W-1:0]  room;
	logic              spill;
	logic [AL_W-1:0]   align;
	logic [TOP_W-1:0]  amask;
	logic [TOP_W-1:0]  aligned;
	logic [TOP_W-1:0]  pad;
	logic [SIZE_W:0]   padded;
	logic              fits;
	logic [SIZE_W-1:0] recorded;
	logic [TOT_W:0]    tsum;
	logic [TOT_W-1:0]  tadd;

	always_comb begin
		arena = ({15'd0, arena_cfg} > 32'(ARENA_MAX)) ? TOP_W'(ARENA_MAX) : arena_cfg;
		limit = ({26'd0, limit_cfg} > 32'(RECORD_DEPTH)) ? CNT_W'(RECORD_DEPTH) : limit_cfg;
		full  = state.count >= limit;
		avail = (state.top < arena) ? arena - state.top : '0;
		room  = avail & ~TOP_W'(MAX_ALIGN - 1);
		spill = item.request_size > SIZE_W'(room);

		// smallest power of two covering the size, capped at MAX_ALIGN
		if (item.request_size >= SIZE_W'(MAX_ALIGN)) begin
			align = AL_W'(MAX_ALIGN);
		end else begin
			align = AL_W'(1);
			for (int i = 0; i < AL_W - 1; i++) begin
				if ((SIZE_W'(1) << i) < item.request_size) begin
					align = AL_W'(1) << (i + 1);
				end
			end
		end
		amask   = TOP_W'(align) - TOP_W'(1);
		aligned = (state.top + amask) & ~amask;
		pad     = aligned - state.top;
		padded  = {1'b0, item.request_size} + (SIZE_W+1)'(pad);
		fits    = padded <= (SIZE_W+1)'(avail);

		if (spill || !fits) begin
			recorded = item.request_size;
		end else begin
			recorded = padded[SIZE_W-1:0];
		end
		tsum = {1'b0, state.total} + (TOT_W+1)'(recorded);
		tadd = tsum[TOT_W] ? '1 : tsum[TOT_W-1:0];

		state_next = state;
		result     = '0;
		rec_we     = 1'b0;
		rec_wdata  = '{spilled: spill, size: recorded};

		if (item.kind == KIND_ALLOC) begin
			if (full) begin
				result.status = ST_FULL;
			end else begin
				rec_we               = 1'b1;
				result.recorded_size = recorded;
				state_next.count     = state.count + CNT_W'(1);
				state_next.total     = tadd;
				state_next.peak      = (tadd > state.peak) ? tadd : state.peak;
				if (spill) begin
					result.status = ST_SPILLED;
				end else begin
					state_next.top = state.top + recorded[TOP_W-1:0];
					if (fits) begin
						result.status       = ST_ARENA;
						result.block_offset = aligned[OFS_W-1:0];
					end else begin
						result.status = ST_NULLBLK;
					end
				end
			end
		end else if (!item.release_nonnull) begin
			result.status = ST_IGNORED;
		end else if (state.count == '0) begin
			result.status = ST_UNDER;
		end else begin
			result.status        = ST_FREED;
			result.recorded_size = rec_top.size;
			state_next.count     = state.count - CNT_W'(1);
			if (!rec_top.spilled) begin
				state_next.top = (SIZE_W'(state.top) >= rec_top.size)
					? state.top - rec_top.size[TOP_W-1:0] : '0;
			end
			state_next.total = (state.total >= TOT_W'(rec_top.size))
				? state.total - TOT_W'(rec_top.size) : '0;
		end

		result.bytes_in_use = state_next.total;
		result.peak_bytes   = state_next.peak;
		result.records_held = state_next.count;
	end

endmodule

/* hw/rtl/lifo_arena_allocator_top.sv */
// LIFO arena allocator top level: input stage, record RAM, result register.
// Depends on laa_pkg, laa_step, laa_ram and lifo_arena_allocator_top_defines.svh.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_ready    kind, request_size, release_nonnull
//   out       source     out_valid/out_ready  status .. records_held
//   cfg       sink       cfg_we               cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ready holds; a result passes the input stage, then the result register.
// The record RAM is read at acceptance, so the address comes from the state the
// staged request leaves; a same-cycle push to that slot is forwarded.
// Reset clears pointers, counters and valids; record contents are left as is.
// A stalled result holds the staged request; the input side accepts while a
// result waits so long as the input stage is free.
`timescale 1ns / 1ps
`include "lifo_arena_allocator_top_defines.svh"
module lifo_arena_allocator_top #(
	parameter int MAX_ALIGN    = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        kind,
	input  logic [laa_pkg::SIZE_W-1:0]  request_size,
	input  logic                        release_nonnull,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [laa_pkg::OFS_W-1:0]   block_offset,
	output logic [laa_pkg::SIZE_W-1:0]  recorded_size,
	output logic [laa_pkg::TOT_W-1:0]   bytes_in_use,
	output logic [laa_pkg::TOT_W-1:0]   peak_bytes,
	output logic [laa_pkg::CNT_W-1:0]   records_held,
	input  logic                        cfg_we,
	input  logic [laa_pkg::IDX_W-1:0]   cfg_index,
	input  logic [laa_pkg::CFG_W-1:0]   cfg_wdata
);
	import laa_pkg::*;

	localparam int AW    = $clog2(RECORD_DEPTH);
	localparam int REC_W = SIZE_W + 1;

	logic [CFG_W-1:0] arena_cfg_q;
	logic [CNT_W-1:0] limit_cfg_q;
	laa_state_t       state_q;
	logic             valid_s1;
	laa_item_t        item_s1;
	logic             byp_s1;
	laa_rec_t         byp_rec_s1;
	logic             valid_s2;
	laa_result_t      res_s2;

	laa_state_t       state_next;
	laa_result_t      result;
	logic             rec_we;
	laa_rec_t         rec_wdata;
	laa_rec_t         rec_top;
	logic [REC_W-1:0] ram_rdata;
	logic             fire_s1;
	logic             accept;
	logic             wr_en;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [CNT_W-1:0] cnt_after;

	assign fire_s1  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire_s1;
	assign accept   = in_valid && in_ready;
	assign wr_en    = fire_s1 && rec_we;
	assign waddr    = AW'(state_q.count);

	// top record slot as seen after the staged request retires
	always_comb begin
		cnt_after = fire_s1 ? state_next.count : state_q.count;
		raddr     = (cnt_after == '0) ? '0 : AW'(cnt_after - CNT_W'(1));
		rec_top   = byp_s1 ? byp_rec_s1 : laa_rec_t'(ram_rdata);
	end

	laa_ram #(
		.WIDTH (REC_W),
		.DEPTH (RECORD_DEPTH)
	) u_rec_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (REC_W'(rec_wdata)),
		.re    (accept),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	laa_step #(
		.MAX_ALIGN    (MAX_ALIGN)
	) u_step (
		.state      (state_q),
		.item       (item_s1),
		.arena_cfg  (arena_cfg_q),
		.limit_cfg  (limit_cfg_q),
		.rec_top    (rec_top),
		.state_next (state_next),
		.result     (result),
		.rec_we     (rec_we),
		.rec_wdata  (rec_wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_cfg_q <= CFG_W'(65536);
			limit_cfg_q <= CNT_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ARENA_BYTES:  arena_cfg_q <= cfg_wdata;
				REG_RECORD_LIMIT: limit_cfg_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire_s1) begin
				state_q <= state_next;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= '{kind: kind, request_size: request_size,
				release_nonnull: release_nonnull};
			byp_s1     <= wr_en && (waddr == raddr);
			byp_rec_s1 <= rec_wdata;
		end
		if (fire_s1) begin
			res_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign status        = res_s2.status;
	assign block_offset  = res_s2.block_offset;
	assign recorded_size = res_s2.recorded_size;
	assign bytes_in_use  = res_s2.bytes_in_use;
	assign peak_bytes    = res_s2.peak_bytes;
	assign records_held  = res_s2.records_held;

	`LAA_ASSERT_NOW(a_peak_covers_total, clk, arst_n, 1'b1, state_q.peak >= state_q.total)
	`LAA_ASSERT_NOW(a_count_in_depth, clk, arst_n, 1'b1, 32'(state_q.count) <= 32'(RECORD_DEPTH))
	`LAA_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire_s1, valid_s2)

endmodule
